// ----- sv/bmhq_pkg.sv -----
`default_nettype none

package bmhq_pkg;

  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 11;
  localparam int POS_W     = 16;
  localparam int LVL_W     = 5;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             op;
    logic [POS_W-1:0] pos;
  } tok_t;

  typedef struct packed {
    logic             done;
    logic             we;
    logic [POS_W-1:0] pos;
  } up_t;

  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] pos;
  } fetch_t;

endpackage

`default_nettype wire

// ----- sv/bmhq_cell.sv -----
`default_nettype none

module bmhq_cell #(
  parameter int LEVEL = 1,
  parameter bit LAST  = 1'b0,
  parameter int VW    = 32,
  parameter int CW    = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bmhq_pkg::tok_t             tok_in,
  input  logic [VW-1:0]              tok_val_in,
  input  logic [bmhq_pkg::POS_W-1:0] ins_pos,
  input  logic [bmhq_pkg::LVL_W-1:0] ins_lvl,
  input  logic [CW-1:0]              cnt,
  input  bmhq_pkg::fetch_t           fetch,
  output logic [VW-1:0]              fetch_data,
  output bmhq_pkg::tok_t             tok_out,
  output logic [VW-1:0]              tok_val_out,
  input  bmhq_pkg::up_t              up_in,
  input  logic [VW-1:0]              up_val_in,
  output bmhq_pkg::up_t              up_out,
  output logic [VW-1:0]              up_val_out
);
  import bmhq_pkg::*;

  localparam int ROWS = 1 << (LEVEL - 1);
  localparam int RW   = (LEVEL > 1) ? LEVEL - 1 : 1;
  localparam logic [CW-1:0] NODE_BASE = CW'(1 << LEVEL);

  logic [VW-1:0] mem_l [ROWS];
  logic [VW-1:0] mem_r [ROWS];

  logic [VW-1:0]    rd_l_r, rd_r_r;
  logic [RW-1:0]    raddr;
  logic             fsel_r, fhalf_r;
  tok_t             st_r, st_nxt;
  logic [VW-1:0]    st_val_r;
  tok_t             tok_out_r, tok_nxt;
  logic [VW-1:0]    tok_val_out_r, tok_val_nxt;
  up_t              up_r, up_nxt;
  logic [VW-1:0]    up_val_r, up_val_nxt;

  logic             fetch_hit, tgt_hit;
  logic             wr_en;
  logic [POS_W-1:0] wr_pos;
  logic [VW-1:0]    wr_data;

  logic [VW-1:0]    ins_e, cmin;
  logic             v_lt_e, lvalid, rvalid, r_sel, descend;
  logic [CW-1:0]    lnode;
  logic [POS_W-1:0] cpos;

  assign fetch_hit = fetch.valid && (fetch.level == LVL_W'(LEVEL));
  assign tgt_hit   = tok_in.valid && (tok_in.op == CMD_INSERT) && (ins_lvl == LVL_W'(LEVEL));

  always_comb begin
    priority if (fetch_hit) begin
      raddr = RW'(fetch.pos >> 1);
    end else if (tok_in.valid && (tok_in.op == CMD_EXTRACT)) begin
      raddr = RW'(tok_in.pos);
    end else begin
      raddr = RW'(ins_pos >> 1);
    end
  end

  assign ins_e   = ins_pos[0] ? rd_r_r : rd_l_r;
  assign v_lt_e  = $signed(st_val_r) < $signed(ins_e);
  assign lnode   = NODE_BASE | (CW'(st_r.pos) << 1);
  assign lvalid  = lnode <= cnt;
  assign rvalid  = lnode < cnt;
  assign r_sel   = rvalid && ($signed(rd_r_r) < $signed(rd_l_r));
  assign cmin    = r_sel ? rd_r_r : rd_l_r;
  assign descend = lvalid && ($signed(cmin) < $signed(st_val_r));
  assign cpos    = (st_r.pos << 1) | POS_W'(r_sel);

  always_comb begin
    st_nxt       = tok_in;
    st_nxt.valid = tok_in.valid && !tgt_hit;
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_pos      = ins_pos;
    wr_data     = tok_val_in;
    tok_nxt     = '0;
    tok_val_nxt = st_val_r;
    up_nxt      = '0;
    up_val_nxt  = st_val_r;
    if (tgt_hit) begin
      wr_en       = 1'b1;
      up_nxt.done = 1'b1;
    end
    if (st_r.valid) begin
      if (st_r.op == CMD_INSERT) begin
        tok_nxt.valid = 1'b1;
        tok_nxt.op    = CMD_INSERT;
        if (v_lt_e) begin
          wr_en       = 1'b1;
          wr_pos      = ins_pos;
          wr_data     = st_val_r;
          tok_val_nxt = ins_e;
        end
      end else begin
        up_nxt.we  = 1'b1;
        up_nxt.pos = st_r.pos;
        if (descend) begin
          up_val_nxt = cmin;
          if (LAST) begin
            wr_en       = 1'b1;
            wr_pos      = cpos;
            wr_data     = st_val_r;
            up_nxt.done = 1'b1;
          end else begin
            tok_nxt.valid = 1'b1;
            tok_nxt.op    = CMD_EXTRACT;
            tok_nxt.pos   = cpos;
          end
        end else begin
          up_nxt.done = 1'b1;
        end
      end
    end
    if (up_in.we) begin
      wr_en   = 1'b1;
      wr_pos  = up_in.pos;
      wr_data = up_val_in;
    end
  end

  always_ff @(posedge clk) begin
    rd_l_r <= mem_l[raddr];
    rd_r_r <= mem_r[raddr];
    if (wr_en && !wr_pos[0]) begin
      mem_l[RW'(wr_pos >> 1)] <= wr_data;
    end
    if (wr_en && wr_pos[0]) begin
      mem_r[RW'(wr_pos >> 1)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      tok_out_r <= '0;
      up_r      <= '0;
      fsel_r    <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      tok_out_r <= tok_nxt;
      up_r      <= up_nxt;
      fsel_r    <= fetch_hit;
    end
  end

  always_ff @(posedge clk) begin
    fhalf_r       <= fetch.pos[0];
    st_val_r      <= tok_val_in;
    tok_val_out_r <= tok_val_nxt;
    up_val_r      <= up_val_nxt;
  end

  assign fetch_data  = fsel_r ? (fhalf_r ? rd_r_r : rd_l_r) : '0;
  assign tok_out     = tok_out_r;
  assign tok_val_out = tok_val_out_r;
  assign up_out      = up_r;
  assign up_val_out  = up_val_r;

endmodule

`default_nettype wire

// ----- sv/binary_min_heap_queue.sv -----
// Priority queue of signed words kept as a binary min-heap: the root in a register, one cell per lower tree level.
// Input channel (in_valid/in_ready): each request carries in_command and in_value_in.
// Command insert adds the value; command extract removes and returns the minimum.
// Output channel (out_valid/out_ready): exactly one result per request, holding the
// removed minimum (zero otherwise), a status (ok, overflow, empty) and the entry count.
// An insert into a full queue or an extract from an empty one reports its status and
// leaves the contents unchanged.
// An insert walks from the root down to the level of the new slot; each level does a
// registered memory read, then a compare and write. An extract first reads the last
// entry and then sifts it down, again a read and then a compare and write at each level.
// Requests that fail or touch only the root skip the level cells.
// One request is in flight at a time; a new request is taken only once the last is done.
// A finished result sits in the output register, so a new request is taken while the
// receiver stalls; a second result waits in the block until that register frees.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module binary_min_heap_queue #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic signed [bmhq_pkg::DATA_W-1:0] in_value_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [bmhq_pkg::DATA_W-1:0] out_value_out,
  output logic [bmhq_pkg::STAT_W-1:0]    out_status,
  output logic [bmhq_pkg::CNT_OUT_W-1:0] out_count
);
  import bmhq_pkg::*;

  localparam int LEVELS = $clog2(DEPTH + 1);
  localparam int CW     = LEVELS;
  localparam int VW     = VALUE_WIDTH;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [CW:0]          pow_r, pow_nxt;
  logic [VW-1:0]        root_r, root_nxt;
  logic [CW-1:0]        path_r, path_nxt;
  logic [LVL_W-1:0]     tgt_r, tgt_nxt;
  tok_t                 tok0_r, tok0_nxt;
  logic [VW-1:0]        tok0_val_r, tok0_val_nxt;
  fetch_t               fetch_r, fetch_nxt;
  logic [VW-1:0]        res_val_r, res_val_nxt;
  logic [STAT_W-1:0]    res_stat_r, res_stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_val_r, out_val_nxt;
  logic [STAT_W-1:0]    out_stat_r, out_stat_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  tok_t             tok_c  [LEVELS+1];
  logic [VW-1:0]    tval_c [LEVELS+1];
  up_t              up_c   [LEVELS+1];
  logic [VW-1:0]    uval_c [LEVELS+1];
  logic [VW-1:0]    fdat_c [LEVELS];
  logic [LEVELS-1:0] done_vec;
  logic [VW-1:0]    fdat_any;

  logic             accept;
  logic [VW-1:0]    ins_v;
  logic             v_lt_root;
  logic             last_ge;
  logic [LVL_W-1:0] last_lvl;
  logic [CW:0]      last_lead;
  logic [CW:0]      last_pos;

  assign tok_c[0]  = '0;
  assign tval_c[0] = '0;
  assign tok_c[1]  = tok0_r;
  assign tval_c[1] = tok0_val_r;
  assign up_c[0]   = '0;
  assign uval_c[0] = '0;
  assign up_c[LEVELS]   = '0;
  assign uval_c[LEVELS] = '0;
  assign fdat_c[0] = '0;
  assign done_vec[0] = 1'b0;

  for (genvar k = 1; k < LEVELS; k++) begin : g_cell
    localparam logic [POS_W-1:0] MASK = POS_W'((1 << k) - 1);
    logic [POS_W-1:0] ipos;

    assign ipos = POS_W'(path_r >> (LEVELS - 1 - k)) & MASK;
    assign done_vec[k] = up_c[k].done;

    bmhq_cell #(
      .LEVEL (k),
      .LAST  (k == LEVELS - 1),
      .VW    (VW),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_in      (tok_c[k]),
      .tok_val_in  (tval_c[k]),
      .ins_pos     (ipos),
      .ins_lvl     (tgt_r),
      .cnt         (count_r),
      .fetch       (fetch_r),
      .fetch_data  (fdat_c[k]),
      .tok_out     (tok_c[k+1]),
      .tok_val_out (tval_c[k+1]),
      .up_in       (up_c[k+1]),
      .up_val_in   (uval_c[k+1]),
      .up_out      (up_c[k]),
      .up_val_out  (uval_c[k])
    );
  end

  always_comb begin
    fdat_any = '0;
    for (int k = 1; k < LEVELS; k++) begin
      fdat_any = fdat_any | fdat_c[k];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ins_v     = VW'(in_value_in);
  assign v_lt_root = $signed(ins_v) < $signed(root_r);

  assign last_ge   = (CW+1)'(count_r) >= pow_r;
  assign last_lvl  = last_ge ? lvl_r : lvl_r - 1'b1;
  assign last_lead = last_ge ? pow_r : (pow_r >> 1);
  assign last_pos  = (CW+1)'(count_r) ^ last_lead;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lvl_nxt       = lvl_r;
    pow_nxt       = pow_r;
    root_nxt      = root_r;
    path_nxt      = path_r;
    tgt_nxt       = tgt_r;
    tok0_nxt      = '0;
    tok0_val_nxt  = tok0_val_r;
    fetch_nxt     = fetch_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;

    if (up_c[1].we) begin
      root_nxt = uval_c[1];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_val_nxt  = '0;
          res_stat_nxt = ST_OK;
          state_nxt    = S_DONE;
          if (in_command == CMD_INSERT) begin
            if (count_r == FULL) begin
              res_stat_nxt = ST_OVERFLOW;
            end else begin
              count_nxt = count_r + 1'b1;
              if (((CW+2)'(count_r) + (CW+2)'(2)) == {pow_r, 1'b0}) begin
                lvl_nxt = lvl_r + 1'b1;
                pow_nxt = pow_r << 1;
              end
              if (count_r == '0) begin
                root_nxt = ins_v;
              end else begin
                root_nxt         = v_lt_root ? ins_v : root_r;
                tok0_nxt.valid   = 1'b1;
                tok0_nxt.op      = CMD_INSERT;
                tok0_val_nxt     = v_lt_root ? root_r : ins_v;
                path_nxt         = (count_r + 1'b1) << (LVL_W'(LEVELS - 1) - lvl_r);
                tgt_nxt          = lvl_r;
                state_nxt        = S_RUN;
              end
            end
          end else begin
            if (count_r == '0) begin
              res_stat_nxt = ST_EMPTY;
            end else begin
              res_val_nxt = root_r;
              count_nxt   = count_r - 1'b1;
              if (((CW+1)'(count_r) + (CW+1)'(1)) == pow_r) begin
                lvl_nxt = lvl_r - 1'b1;
                pow_nxt = pow_r >> 1;
              end
              if (count_r != CW'(1)) begin
                fetch_nxt.valid = 1'b1;
                fetch_nxt.level = last_lvl;
                fetch_nxt.pos   = POS_W'(last_pos);
                state_nxt       = S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        fetch_nxt.valid = 1'b0;
        state_nxt       = S_LOAD;
      end
      S_LOAD: begin
        tok0_nxt.valid = 1'b1;
        tok0_nxt.op    = CMD_EXTRACT;
        tok0_val_nxt   = fdat_any;
        state_nxt      = S_RUN;
      end
      S_RUN: begin
        if (|done_vec) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = DATA_W'(res_val_r);
          out_stat_nxt  = res_stat_r;
          out_cnt_nxt   = CNT_OUT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lvl_r       <= '0;
      pow_r       <= (CW+1)'(1);
      tok0_r      <= '0;
      fetch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lvl_r       <= lvl_nxt;
      pow_r       <= pow_nxt;
      tok0_r      <= tok0_nxt;
      fetch_r     <= fetch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r     <= root_nxt;
    path_r     <= path_nxt;
    tgt_r      <= tgt_nxt;
    tok0_val_r <= tok0_val_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_val_r;
  assign out_status    = out_stat_r;
  assign out_count     = out_cnt_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("Entry count exceeds the heap depth.");

  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_vec))
    else $error("More than one level cell finished at once.");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (|done_vec) |-> (state_r == S_RUN))
    else $error("A level cell finished while no sift was running.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_count == '0))
    else $error("Empty status reported with a nonzero count.");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH = 1024;
  localparam int LONG_HOLD  = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT = 60;
  localparam int RANDOM_REQUESTS = 700;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic [CNT_OUT_W-1:0]     count;
  } heap_result_t;

  class heap_scoreboard;
    logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    int unsigned n_entries;
    heap_result_t expected_q[$];
    int errors;

    function new();
      n_entries = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      logic signed [DATA_W-1:0] t;
      t = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
    endfunction

    function void note_request(logic cmd, logic signed [DATA_W-1:0] value);
      heap_result_t r;
      int unsigned pos, up, left, right, best;
      r.value = '0;
      r.status = ST_OK;
      if (cmd == CMD_INSERT) begin
        if (n_entries >= HEAP_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          heap_mem[n_entries] = value;
          pos = n_entries;
          n_entries++;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_mem[pos] >= heap_mem[up]) break;
            swap_entries(up, pos);
            pos = up;
          end
        end
      end else begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = heap_mem[0];
          n_entries--;
          heap_mem[0] = heap_mem[n_entries];
          pos = 0;
          forever begin
            left = 2 * pos + 1;
            right = left + 1;
            best = pos;
            if (left < n_entries && heap_mem[left] < heap_mem[best]) best = left;
            if (right < n_entries && heap_mem[right] < heap_mem[best]) best = right;
            if (best == pos) break;
            swap_entries(best, pos);
            pos = best;
          end
        end
      end
      r.count = n_entries[CNT_OUT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] value, logic [STAT_W-1:0] status,
                               logic [CNT_OUT_W-1:0] count);
      heap_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result: value %0d status %0d count %0d", value, status, count);
        return;
      end
      e = expected_q.pop_front();
      if (value !== e.value || status !== e.status || count !== e.count) begin
        errors++;
        if (errors <= 10)
          $display("Bad result: value %0d/%0d status %0d/%0d count %0d/%0d (expected/actual)",
                   e.value, value, e.status, status, e.count, count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_command;
  logic signed [DATA_W-1:0] in_value_in;
  logic out_valid;
  logic out_ready;
  logic signed [DATA_W-1:0] out_value_out;
  logic [STAT_W-1:0] out_status;
  logic [CNT_OUT_W-1:0] out_count;

  heap_scoreboard sb;
  int level = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  int quiet_cycles = 0;

  binary_min_heap_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_value_in(in_value_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value_out(out_value_out),
    .out_status(out_status),
    .out_count(out_count)
  );

  always #1 clk = ~clk;

  function int pick_gap();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic signed [DATA_W-1:0] value);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_value_in <= value;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_INSERT) begin
      if (level < HEAP_DEPTH) level++;
    end else if (level > 0) begin
      level--;
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_mixed(input int len);
    int p_ins;
    repeat (len) begin
      p_ins = (level < 4) ? 80 : ((level > 200) ? 30 : 55);
      send_request(($urandom_range(0, 99) < p_ins) ? CMD_INSERT : CMD_EXTRACT, rand_value());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_command, in_value_in);
      if (out_valid && out_ready) sb.check_result(out_value_out, out_status, out_count);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int n_rand;
    int len;
    bit fill_done;
    n_rand = 0;
    fill_done = 1'b0;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_INSERT;
    in_value_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty extract, extreme values, repeated values for equal children.
    send_request(CMD_EXTRACT, 32'sh1234_5678);
    send_request(CMD_INSERT, 32'sh0000_0000);
    send_request(CMD_INSERT, -32'sd1);
    send_request(CMD_INSERT, 32'sh7fff_ffff);
    send_request(CMD_INSERT, 32'sh8000_0000);
    send_request(CMD_INSERT, 32'sd5);
    send_request(CMD_INSERT, 32'sd5);
    send_request(CMD_INSERT, 32'sh5555_5555);
    send_request(CMD_INSERT, 32'shaaaa_aaaa);
    send_request(CMD_INSERT, -32'sd1);
    repeat (10) send_request(CMD_EXTRACT, rand_value());
    wait_drain();

    while (n_rand < RANDOM_REQUESTS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(8, 40);
          send_mixed(len);
        end
        6, 7: begin
          len = $urandom_range(10, 60);
          repeat (len) send_request(CMD_INSERT, rand_value());
        end
        8: begin
          len = level + $urandom_range(1, 2);
          repeat (len) send_request(CMD_EXTRACT, rand_value());
        end
        default: begin
          len = 0;
          wait_drain();
        end
      endcase
      n_rand += len;

      if (n_rand >= RANDOM_REQUESTS / 2 && !fill_done) begin
        // Keep offering inserts while the receiver is held off, then empty the queue.
        fill_done = 1'b1;
        tx_idle_on = 1'b0;
        long_hold_req = 1'b1;
        len = 40;
        repeat (len) send_request(CMD_INSERT, rand_value());
        n_rand += len;
        wait_drain();
        tx_idle_on = 1'b1;
        len = level + 2;
        repeat (len) send_request(CMD_EXTRACT, rand_value());
        n_rand += len;
      end
    end

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- binary_min_heap_queue.f -----
sv/bmhq_pkg.sv
sv/bmhq_cell.sv
sv/binary_min_heap_queue.sv
tb/tb.sv
